// File: rtl/mmpd_pkg.sv
// Shared types and constants of the min/max plot decimator.
package mmpd_pkg;

  // APB data and address widths
  localparam int unsigned APB_DW = 32;
  localparam int unsigned APB_AW = 5;

  // Depth of the vertex record queue and width of its counters
  localparam int unsigned QUEUE_DEPTH = 8;
  localparam int unsigned QUEUE_AW    = 3;
  localparam int unsigned QUEUE_CW    = 4;

  // Configuration register indexes (byte address is 4 * index)
  typedef enum logic [2:0] {
    REG_LEFT_EDGE   = 3'd0,
    REG_BOTTOM_EDGE = 3'd1,
    REG_TIME_START  = 3'd2,
    REG_TIME_SCALE  = 3'd3,
    REG_VALUE_LOW   = 3'd4,
    REG_VALUE_SCALE = 3'd5
  } reg_idx_e;

  // One input sample
  typedef struct packed {
    logic [31:0]        sample_time;
    logic signed [23:0] sample_value;
    logic               line_end;
  } sample_t;

  // One polyline vertex
  typedef struct packed {
    logic [14:0]        point_x;
    logic signed [15:0] point_y;
    logic               run_last;
    logic               line_done;
  } point_t;

  // Configuration register contents
  typedef struct packed {
    logic [14:0]        left_edge;
    logic [14:0]        bottom_edge;
    logic [31:0]        time_start;
    logic [31:0]        time_scale;
    logic signed [23:0] value_low;
    logic [31:0]        value_scale;
  } cfg_t;

  // Vertices that one sample causes, emitted from bit 0 upwards
  typedef struct packed {
    logic fin;
    logic cur;
    logic prev;
    logic max;
    logic min;
  } vert_mask_t;

  // Classified sample: everything the back end needs to emit its vertices
  typedef struct packed {
    logic [14:0]        col;
    logic signed [15:0] min_row;
    logic signed [15:0] max_row;
    logic signed [15:0] prev_row;
    logic [14:0]        new_x;
    logic signed [15:0] new_y;
    vert_mask_t         mask;
  } rec_t;

endpackage

// File: rtl/mmpd_regs.sv
// APB configuration registers of the min/max plot decimator.
module mmpd_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mmpd_pkg::APB_AW-1:0] paddr,
  input  logic [mmpd_pkg::APB_DW-1:0] pwdata,
  output logic [mmpd_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  output mmpd_pkg::cfg_t              cfg_o
);

  mmpd_pkg::cfg_t      cfg_q;
  mmpd_pkg::reg_idx_e  idx;
  logic                wr_en;

  assign idx    = mmpd_pkg::reg_idx_e'(paddr[mmpd_pkg::APB_AW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Write a register at the access phase of a write transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.left_edge   <= 15'd0;
      cfg_q.bottom_edge <= 15'd0;
      cfg_q.time_start  <= 32'd0;
      cfg_q.time_scale  <= 32'd65536;
      cfg_q.value_low   <= 24'sd0;
      cfg_q.value_scale <= 32'd65536;
    end else if (wr_en) begin
      unique case (idx)
        mmpd_pkg::REG_LEFT_EDGE:   cfg_q.left_edge   <= pwdata[14:0];
        mmpd_pkg::REG_BOTTOM_EDGE: cfg_q.bottom_edge <= pwdata[14:0];
        mmpd_pkg::REG_TIME_START:  cfg_q.time_start  <= pwdata;
        mmpd_pkg::REG_TIME_SCALE:  cfg_q.time_scale  <= pwdata;
        mmpd_pkg::REG_VALUE_LOW:   cfg_q.value_low   <= pwdata[23:0];
        mmpd_pkg::REG_VALUE_SCALE: cfg_q.value_scale <= pwdata;
        default: ;
      endcase
    end
  end

  // Return the addressed register, sign-extending the signed one
  always_comb begin
    unique case (idx)
      mmpd_pkg::REG_LEFT_EDGE:   prdata = {17'd0, cfg_q.left_edge};
      mmpd_pkg::REG_BOTTOM_EDGE: prdata = {17'd0, cfg_q.bottom_edge};
      mmpd_pkg::REG_TIME_START:  prdata = cfg_q.time_start;
      mmpd_pkg::REG_TIME_SCALE:  prdata = cfg_q.time_scale;
      mmpd_pkg::REG_VALUE_LOW:   prdata = {{8{cfg_q.value_low[23]}}, cfg_q.value_low};
      mmpd_pkg::REG_VALUE_SCALE: prdata = cfg_q.value_scale;
      default:                   prdata = '0;
    endcase
  end

endmodule

// File: rtl/mmpd_front.sv
// Front end: maps samples to screen coordinates and classifies column changes.
module mmpd_front #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  mmpd_pkg::sample_t sample_i,
  input  mmpd_pkg::cfg_t    cfg_i,
  output logic              enq_o,
  output mmpd_pkg::rec_t    rec_o,
  input  logic              deq_i
);

  localparam int unsigned LIM_RAW   = (1 << (COORD_BITS - 1)) - 1;
  localparam int unsigned COORD_LIM = (LIM_RAW > 32767) ? 32767 : LIM_RAW;
  localparam logic signed [50:0] X_HI = 51'(COORD_LIM);
  localparam logic signed [35:0] Y_HI = 36'(COORD_LIM);
  localparam logic signed [35:0] Y_LO = -Y_HI - 36'sd1;

  logic                             accept;
  logic [3:0]                       vld_q;
  logic [3:0]                       end_q;
  logic [mmpd_pkg::QUEUE_CW-1:0]    credit_q, credit_d;

  logic signed [32:0] dt_q;
  logic signed [24:0] dv_q;
  logic signed [65:0] pt_q, pt_sum;
  logic signed [57:0] pv_q, pv_sum;
  logic signed [49:0] rt_q;
  logic signed [33:0] rv_q;
  logic signed [50:0] xs;
  logic signed [35:0] ys;
  logic [14:0]        x_d, x_q;
  logic signed [15:0] y_d, y_q;

  logic               col_valid_q, emitted_q;
  logic [14:0]        cur_col_q;
  logic signed [15:0] prev_q, min_q, max_q;
  logic               change, gap, emitted_nx;
  mmpd_pkg::vert_mask_t mask;
  logic               drop;

  assign accept = push && !full;
  assign full   = (credit_q >= mmpd_pkg::QUEUE_CW'(mmpd_pkg::QUEUE_DEPTH));

  // Count samples in flight or queued so the queue can never overflow
  always_comb begin
    credit_d = credit_q;
    if (accept) credit_d = credit_d + mmpd_pkg::QUEUE_CW'(1);
    if (drop)   credit_d = credit_d - mmpd_pkg::QUEUE_CW'(1);
    if (deq_i)  credit_d = credit_d - mmpd_pkg::QUEUE_CW'(1);
  end

  // Advance the valid and line-end flags through the mapping stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      end_q    <= '0;
      credit_q <= '0;
    end else begin
      vld_q    <= {vld_q[2:0], accept};
      end_q    <= {end_q[2:0], sample_i.line_end};
      credit_q <= credit_d;
    end
  end

  // Round half up: add half an LSB, then take the floor of the shift
  assign pt_sum = pt_q + 66'sd32768;
  assign pv_sum = pv_q + 58'sd8388608;

  // Add the edges and saturate to the coordinate range
  assign xs = $signed({36'd0, cfg_i.left_edge}) + $signed({rt_q[49], rt_q});
  assign ys = $signed({21'd0, cfg_i.bottom_edge}) - $signed({{2{rv_q[33]}}, rv_q});

  always_comb begin
    if (xs < 51'sd0)     x_d = 15'd0;
    else if (xs > X_HI)  x_d = X_HI[14:0];
    else                 x_d = xs[14:0];
    if (ys > Y_HI)       y_d = Y_HI[15:0];
    else if (ys < Y_LO)  y_d = Y_LO[15:0];
    else                 y_d = ys[15:0];
  end

  // Mapping datapath: offset, multiply, round, edge and clamp
  always_ff @(posedge clk_i) begin
    dt_q <= $signed({1'b0, sample_i.sample_time}) - $signed({1'b0, cfg_i.time_start});
    dv_q <= $signed({sample_i.sample_value[23], sample_i.sample_value})
          - $signed({cfg_i.value_low[23], cfg_i.value_low});
    pt_q <= dt_q * $signed({1'b0, cfg_i.time_scale});
    pv_q <= dv_q * $signed({1'b0, cfg_i.value_scale});
    rt_q <= pt_sum[65:16];
    rv_q <= pv_sum[57:24];
    x_q  <= x_d;
    y_q  <= y_d;
  end

  // Classify the mapped sample against the open column
  assign change     = col_valid_q && (x_q != cur_col_q);
  assign gap        = change && ({1'b0, x_q} > ({1'b0, cur_col_q} + 16'd1));
  assign emitted_nx = emitted_q || change;

  always_comb begin
    mask.min  = change;
    mask.max  = change && (max_q != min_q);
    mask.prev = gap;
    mask.cur  = gap;
    mask.fin  = end_q[3] && emitted_nx;
  end

  assign enq_o = vld_q[3] && (mask != '0);
  assign drop  = vld_q[3] && (mask == '0);

  always_comb begin
    rec_o.col      = cur_col_q;
    rec_o.min_row  = min_q;
    rec_o.max_row  = max_q;
    rec_o.prev_row = prev_q;
    rec_o.new_x    = x_q;
    rec_o.new_y    = y_q;
    rec_o.mask     = mask;
  end

  // Update the column state; a line end returns it to reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_valid_q <= 1'b0;
      emitted_q   <= 1'b0;
      cur_col_q   <= 15'd0;
      prev_q      <= 16'sd0;
      min_q       <= 16'sh7fff;
      max_q       <= 16'sh8000;
    end else if (vld_q[3]) begin
      if (end_q[3]) begin
        col_valid_q <= 1'b0;
        emitted_q   <= 1'b0;
        cur_col_q   <= 15'd0;
        prev_q      <= 16'sd0;
        min_q       <= 16'sh7fff;
        max_q       <= 16'sh8000;
      end else begin
        col_valid_q <= 1'b1;
        emitted_q   <= emitted_nx;
        cur_col_q   <= x_q;
        prev_q      <= y_q;
        // A fresh column starts its extremes at this row
        if (!col_valid_q || change) begin
          min_q <= y_q;
          max_q <= y_q;
        end else begin
          if (y_q < min_q) min_q <= y_q;
          if (y_q > max_q) max_q <= y_q;
        end
      end
    end
  end

endmodule

// File: rtl/mmpd_queue.sv
// Record queue that decouples the classifier from the vertex emitter.
module mmpd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  mmpd_pkg::rec_t wr_rec_i,
  input  logic           rd_i,
  output logic           rd_valid_o,
  output mmpd_pkg::rec_t rd_rec_o
);

  mmpd_pkg::rec_t                mem_q [mmpd_pkg::QUEUE_DEPTH];
  logic [mmpd_pkg::QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [mmpd_pkg::QUEUE_CW-1:0] cnt_q;

  assign rd_valid_o = (cnt_q != '0);
  assign rd_rec_o   = mem_q[rd_ptr_q];

  // Store a record at the write pointer
  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wr_ptr_q] <= wr_rec_i;
  end

  // Advance the pointers and track the fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_i) wr_ptr_q <= wr_ptr_q + mmpd_pkg::QUEUE_AW'(1);
      if (rd_i) rd_ptr_q <= rd_ptr_q + mmpd_pkg::QUEUE_AW'(1);
      if (wr_i && !rd_i)      cnt_q <= cnt_q + mmpd_pkg::QUEUE_CW'(1);
      else if (rd_i && !wr_i) cnt_q <= cnt_q - mmpd_pkg::QUEUE_CW'(1);
    end
  end

endmodule

// File: rtl/mmpd_back.sv
// Back end: expands each record into its vertices, one per transaction.
module mmpd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  mmpd_pkg::rec_t  q_rec_i,
  output logic            q_pop_o,
  output logic            empty,
  input  logic            pop,
  output mmpd_pkg::point_t point_o
);

  mmpd_pkg::rec_t rec_q;
  logic [4:0]     left_q, left_d;
  logic [4:0]     first;
  logic           single;
  mmpd_pkg::vert_mask_t sel;

  assign empty  = (left_q == '0);
  assign first  = left_q & (~left_q + 5'd1);
  assign single = ((left_q & (left_q - 5'd1)) == '0);
  assign sel    = mmpd_pkg::vert_mask_t'(first);

  // Load the next record when idle or when the last vertex leaves
  assign q_pop_o = q_valid_i && (empty || (pop && single));

  always_comb begin
    left_d = left_q;
    if (pop && !empty) left_d = left_q & ~first;
    if (q_pop_o)       left_d = q_rec_i.mask;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) left_q <= '0;
    else         left_q <= left_d;
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) rec_q <= q_rec_i;
  end

  // Drive the oldest pending vertex
  always_comb begin
    point_o.point_x   = (sel.cur || sel.fin) ? rec_q.new_x : rec_q.col;
    point_o.point_y   = rec_q.new_y;
    if (sel.min)       point_o.point_y = rec_q.min_row;
    else if (sel.max)  point_o.point_y = rec_q.max_row;
    else if (sel.prev) point_o.point_y = rec_q.prev_row;
    point_o.run_last  = single;
    point_o.line_done = sel.fin;
  end

endmodule

// File: rtl/min_max_plot_decimator_top.sv
// Top level of the min/max plot decimator.
// Takes one sample per clock cycle as long as full is low. Each sample passes a four-stage
// mapping pipeline (offset, a 33x33 time and a 25x33 value multiply, round, edge add and
// clamp) and is then classified against the open column; a sample that causes vertices
// lands, as one record, in an eight-entry queue, and the back end hands out its vertices one
// per cycle while pop is high. full rises once eight samples are in the pipeline or waiting
// in the queue, so sustained input falls below one per cycle only while the consumer pops
// fewer vertices than the stream produces. Configuration is written through the APB port;
// the user must do so only while idle, as the block itself does not enforce it.
module min_max_plot_decimator_top #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  mmpd_pkg::sample_t           sample_i,
  output logic                        empty,
  input  logic                        pop,
  output mmpd_pkg::point_t            point_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mmpd_pkg::APB_AW-1:0] paddr,
  input  logic [mmpd_pkg::APB_DW-1:0] pwdata,
  output logic [mmpd_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);

  mmpd_pkg::cfg_t cfg;
  mmpd_pkg::rec_t enq_rec, deq_rec;
  logic           enq, deq, deq_valid;

  mmpd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mmpd_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .sample_i (sample_i),
    .cfg_i    (cfg),
    .enq_o    (enq),
    .rec_o    (enq_rec),
    .deq_i    (deq)
  );

  mmpd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (enq),
    .wr_rec_i   (enq_rec),
    .rd_i       (deq),
    .rd_valid_o (deq_valid),
    .rd_rec_o   (deq_rec)
  );

  mmpd_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (deq_valid),
    .q_rec_i   (deq_rec),
    .q_pop_o   (deq),
    .empty     (empty),
    .pop       (pop),
    .point_o   (point_o)
  );

endmodule
